FILE: sv/pcfs_pkg.sv
// shared types and constants of the periodic client frame scheduler
package pcfs_pkg;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_REG   = 2'd1;
  localparam logic [1:0] KIND_DEREG = 2'd2;

  localparam int          MAX_OUT   = 16;
  localparam logic [23:0] SLACK_RST = 24'd10000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [23:0] ivl;
    logic        unlim;
    logic [19:0] frames;
    logic [47:0] now;
  } cmd_t;

  typedef struct packed {
    logic [3:0] client;
    logic       frame;
    logic       fin;
  } res_t;

endpackage

FILE: sv/pcfs_front.sv
// front end: classifies input words and builds queue commands
module pcfs_front #(
  parameter int CLIENTS = 16
) (
  input  logic               [1:0]  in_kind,
  input  logic               [3:0]  in_client_id,
  input  logic               [23:0] in_interval_us,
  input  logic signed        [20:0] in_frame_count,
  input  logic               [47:0] in_now_us,
  output pcfs_pkg::cmd_t            cmd,
  output logic                      keep
);
  import pcfs_pkg::*;

  logic id_ok;

  assign id_ok = (32'(in_client_id) < 32'(CLIENTS));

  always_comb begin
    cmd.kind   = in_kind;
    cmd.id     = in_client_id;
    cmd.ivl    = (in_interval_us == 24'd0) ? 24'd1 : in_interval_us;
    cmd.unlim  = in_frame_count[20];
    cmd.frames = in_frame_count[20] ? 20'd0 : in_frame_count[19:0];
    cmd.now    = in_now_us;
    case (in_kind)
      KIND_TICK:  keep = 1'b1;
      KIND_REG:   keep = id_ok && (in_frame_count != 21'sd0);
      KIND_DEREG: keep = id_ok;
      default:    keep = 1'b0;
    endcase
  end

endmodule

FILE: sv/pcfs_queue.sv
// two-entry command queue between front and back end
module pcfs_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcfs_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output pcfs_pkg::cmd_t dout,
  output logic           avail
);
  import pcfs_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign avail = (cnt_r != 2'd0);
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_r ^ push;
      rp_r  <= rp_r ^ pop;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: sv/pcfs_back.sv
// back end: client table, due-order scan and result output register
module pcfs_back #(
  parameter int CLIENTS   = 16,
  parameter int TIME_BITS = 48
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [23:0]    slack,
  input  logic           cmd_vld,
  input  pcfs_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     out_served_client,
  output logic           out_frame_delivered,
  output logic           out_finished,
  output logic           out_last
);
  import pcfs_pkg::*;

  localparam int IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int CW = $clog2(CLIENTS + 1);
  localparam int NW = $clog2(MAX_OUT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SERVE = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  logic [TIME_BITS-1:0] due_mem [CLIENTS];
  logic [23:0]          per_mem [CLIENTS];
  logic [19:0]          frm_mem [CLIENTS];
  logic                 unl_mem [CLIENTS];

  logic [TIME_BITS-1:0] rd_due_r;
  logic [23:0]          rd_per_r;
  logic [19:0]          rd_frm_r;
  logic                 rd_unl_r;

  logic                 we;
  logic [IW-1:0]        wa, ra;
  logic [TIME_BITS-1:0] wdue;
  logic [23:0]          wper;
  logic [19:0]          wfrm;
  logic                 wunl;

  logic [1:0]           state_r, state_nxt;
  logic [CLIENTS-1:0]   valid_r, valid_nxt;
  logic [CLIENTS-1:0]   ready_r, ready_nxt;
  logic [CW-1:0]        active_r, active_nxt;
  logic [TIME_BITS-1:0] limit_r, limit_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]        ev_idx_r, ev_idx_nxt;
  logic                 first_r, first_nxt;
  logic                 best_vld_r, best_vld_nxt;
  logic [IW-1:0]        best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_due_r, best_due_nxt;
  logic [23:0]          best_per_r, best_per_nxt;
  logic [19:0]          best_frm_r, best_frm_nxt;
  logic                 best_unl_r, best_unl_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  res_t                 pend_r, pend_nxt;
  logic                 out_vld_r, out_vld_nxt;
  res_t                 out_r, out_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 out_free;
  logic                 cand;
  logic [IW-1:0]        cid;
  logic [TIME_BITS-1:0] now_t;
  logic [NW-1:0]        n_inc;

  assign out_free = !out_vld_r || out_ready;
  assign cid      = IW'(cmd.id);
  assign now_t    = TIME_BITS'(cmd.now);
  assign n_inc    = n_r + NW'(1);
  assign ra       = (cnt_r < CW'(CLIENTS)) ? cnt_r[IW-1:0] : '0;

  always_comb begin
    state_nxt    = state_r;
    valid_nxt    = valid_r;
    ready_nxt    = ready_r;
    active_nxt   = active_r;
    limit_nxt    = limit_r;
    cnt_nxt      = cnt_r;
    first_nxt    = first_r;
    best_vld_nxt = best_vld_r;
    best_idx_nxt = best_idx_r;
    best_due_nxt = best_due_r;
    best_per_nxt = best_per_r;
    best_frm_nxt = best_frm_r;
    best_unl_nxt = best_unl_r;
    n_nxt        = n_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    cmd_pop      = 1'b0;
    we           = 1'b0;
    wa           = best_idx_r;
    wdue         = best_due_r;
    wper         = best_per_r;
    wfrm         = best_frm_r;
    wunl         = best_unl_r;
    cand         = 1'b0;
    ev_vld_nxt   = (state_r == ST_SCAN) && (cnt_r < CW'(CLIENTS));
    ev_idx_nxt   = cnt_r[IW-1:0];

    // scan evaluation, one entry a cycle
    if (ev_vld_r) begin
      cand = first_r ? (valid_r[ev_idx_r] && (rd_due_r <= limit_r)) : ready_r[ev_idx_r];
      if (first_r) begin
        ready_nxt[ev_idx_r] = cand;
      end
      if (cand && (!best_vld_r || (rd_due_r < best_due_r))) begin
        best_vld_nxt = 1'b1;
        best_idx_nxt = ev_idx_r;
        best_due_nxt = rd_due_r;
        best_per_nxt = rd_per_r;
        best_frm_nxt = rd_frm_r;
        best_unl_nxt = rd_unl_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_REG: begin
              if (!valid_r[cid]) begin
                we             = 1'b1;
                wa             = cid;
                wdue           = sat_add(now_t, TIME_BITS'(slack));
                wper           = cmd.ivl;
                wfrm           = cmd.frames;
                wunl           = cmd.unlim;
                valid_nxt[cid] = 1'b1;
                active_nxt     = active_r + CW'(1);
              end
            end
            KIND_DEREG: begin
              if (valid_r[cid]) begin
                valid_nxt[cid] = 1'b0;
                active_nxt     = active_r - CW'(1);
                pend_nxt       = '{client: cmd.id, frame: 1'b0, fin: 1'b1};
                pend_vld_nxt   = 1'b1;
                state_nxt      = ST_DONE;
              end
            end
            KIND_TICK: begin
              limit_nxt    = sat_add(now_t, (active_r == CW'(1)) ? '0
                                                                  : TIME_BITS'(slack));
              cnt_nxt      = '0;
              first_nxt    = 1'b1;
              best_vld_nxt = 1'b0;
              n_nxt        = '0;
              state_nxt    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(CLIENTS)) begin
          state_nxt = ST_SERVE;
        end
      end
      ST_SERVE: begin
        if (!best_vld_r) begin
          state_nxt = ST_DONE;
        end else if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_nxt      = pend_r;
            out_last_nxt = 1'b0;
          end
          ready_nxt[best_idx_r] = 1'b0;
          first_nxt             = 1'b0;
          n_nxt                 = n_inc;
          if (!best_unl_r && (best_frm_r == 20'd1)) begin
            valid_nxt[best_idx_r] = 1'b0;
            active_nxt            = active_r - CW'(1);
            pend_nxt = '{client: 4'(best_idx_r), frame: 1'b1, fin: 1'b1};
          end else begin
            we       = 1'b1;
            wdue     = sat_add(best_due_r, TIME_BITS'(best_per_r));
            wfrm     = best_unl_r ? best_frm_r : best_frm_r - 20'd1;
            pend_nxt = '{client: 4'(best_idx_r), frame: 1'b1, fin: 1'b0};
          end
          pend_vld_nxt = 1'b1;
          best_vld_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = (n_inc == NW'(MAX_OUT)) ? ST_DONE : ST_SCAN;
        end
      end
      ST_DONE: begin
        if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_nxt      = pend_r;
          out_last_nxt = 1'b1;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      due_mem[wa] <= wdue;
      per_mem[wa] <= wper;
      frm_mem[wa] <= wfrm;
      unl_mem[wa] <= wunl;
    end
    rd_due_r <= due_mem[ra];
    rd_per_r <= per_mem[ra];
    rd_frm_r <= frm_mem[ra];
    rd_unl_r <= unl_mem[ra];
  end

  always_ff @(posedge clk) begin
    limit_r    <= limit_nxt;
    cnt_r      <= cnt_nxt;
    ev_idx_r   <= ev_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_due_r <= best_due_nxt;
    best_per_r <= best_per_nxt;
    best_frm_r <= best_frm_nxt;
    best_unl_r <= best_unl_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      valid_r    <= '0;
      ready_r    <= '0;
      active_r   <= '0;
      ev_vld_r   <= 1'b0;
      first_r    <= 1'b0;
      best_vld_r <= 1'b0;
      n_r        <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      valid_r    <= valid_nxt;
      ready_r    <= ready_nxt;
      active_r   <= active_nxt;
      ev_vld_r   <= ev_vld_nxt;
      first_r    <= first_nxt;
      best_vld_r <= best_vld_nxt;
      n_r        <= n_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_served_client   = out_r.client;
  assign out_frame_delivered = out_r.frame;
  assign out_finished        = out_r.fin;
  assign out_last            = out_last_r;

endmodule

FILE: sv/periodic_client_frame_scheduler_top.sv
// top level of the periodic client frame scheduler
// register words are handled in the idle state, deregister words go on to the done state for their notice
// a tick takes one table scan per served client plus a last scan unless MAX_OUT were served,
// plus output stalls; the table's single read port, read one entry at a time, sets this
// a two-word queue lets new words be taken while the back end works
// rst_n is synchronous: table empty, slack back to 10000, queue and output empty
module periodic_client_frame_scheduler_top #(
  parameter int CLIENTS   = 16,
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  in_kind,
  input  logic        [3:0]  in_client_id,
  input  logic        [23:0] in_interval_us,
  input  logic signed [20:0] in_frame_count,
  input  logic        [47:0] in_now_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [3:0]  out_served_client,
  output logic               out_frame_delivered,
  output logic               out_finished,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic        [23:0] cfg_wdata
);
  import pcfs_pkg::*;

  logic [23:0] slack_r;
  cmd_t        f_cmd, q_cmd;
  logic        f_keep, q_full, q_avail, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r <= SLACK_RST;
    end else if (cfg_we) begin
      slack_r <= cfg_wdata;
    end
  end

  assign in_ready = !q_full;

  pcfs_front #(.CLIENTS(CLIENTS)) u_front (
    .in_kind        (in_kind),
    .in_client_id   (in_client_id),
    .in_interval_us (in_interval_us),
    .in_frame_count (in_frame_count),
    .in_now_us      (in_now_us),
    .cmd            (f_cmd),
    .keep           (f_keep)
  );

  pcfs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_valid && in_ready && f_keep),
    .din   (f_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_cmd),
    .avail (q_avail)
  );

  pcfs_back #(.CLIENTS(CLIENTS), .TIME_BITS(TIME_BITS)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .slack               (slack_r),
    .cmd_vld             (q_avail),
    .cmd                 (q_cmd),
    .cmd_pop             (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_served_client   (out_served_client),
    .out_frame_delivered (out_frame_delivered),
    .out_finished        (out_finished),
    .out_last            (out_last)
  );

  // a notice without a frame is the single result of a deregister
  a_notice_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_delivered |-> out_finished && out_last)
    else $error("notice word not marked finished and last");

  // every word that does not retire a client carries a frame
  a_live_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_frame_delivered)
    else $error("word with neither frame nor finish");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present after reset");

endmodule
